>>> sv/assert_macros.svh
// Assertion macros used by the deframer result queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every sampled edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// Consequent that must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> sv/id3d_pkg.sv
// Types, codes and the old-ID translation table of the ID3v2 deframer.
package id3d_pkg;

    localparam int ROM_SIZE = 64;

    localparam logic [2:0] KIND_PAYLOAD = 3'd1;
    localparam logic [2:0] KIND_EMPTY   = 3'd2;
    localparam logic [2:0] KIND_FINISH  = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    localparam logic [3:0] FAULT_NONE      = 4'd0;
    localparam logic [3:0] FAULT_HEADER    = 4'd1;
    localparam logic [3:0] FAULT_SYNCHSAFE = 4'd2;
    localparam logic [3:0] FAULT_FRAME_ID  = 4'd3;
    localparam logic [3:0] FAULT_COMPRESS  = 4'd4;
    localparam logic [3:0] FAULT_SMALL     = 4'd5;
    localparam logic [3:0] FAULT_EXT_SMALL = 4'd6;
    localparam logic [3:0] FAULT_EXT_LARGE = 4'd7;
    localparam logic [3:0] FAULT_OVERRUN   = 4'd8;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] code;
        logic [7:0]  pbyte;
        logic        first;
        logic        last;
        logic [2:0]  major;
        logic [3:0]  fault;
    } result_t;

    localparam logic [31:0] OLD_ID [ROM_SIZE] = '{
        32'h00425546, 32'h00434E54, 32'h00434F4D, 32'h00435241,
        32'h00455443, 32'h0047454F, 32'h0049504C, 32'h004D4349,
        32'h004D4C4C, 32'h00504943, 32'h00504F50, 32'h00524556,
        32'h00534C54, 32'h00535443, 32'h0054414C, 32'h00544250,
        32'h0054434D, 32'h0054434F, 32'h00544350, 32'h00544352,
        32'h00544459, 32'h0054454E, 32'h00544654, 32'h00544B45,
        32'h00544C41, 32'h00544D54, 32'h00544F41, 32'h00544F46,
        32'h00544F4C, 32'h00544F52, 32'h00544F54, 32'h00545031,
        32'h00545032, 32'h00545033, 32'h00545034, 32'h00545041,
        32'h00545042, 32'h00545243, 32'h00545244, 32'h0054524B,
        32'h00545332, 32'h00545341, 32'h00545343, 32'h00545350,
        32'h00545353, 32'h00545354, 32'h00545431, 32'h00545432,
        32'h00545433, 32'h00545854, 32'h00545858, 32'h00545945,
        32'h00554649, 32'h00554C54, 32'h00574146, 32'h00574152,
        32'h00574153, 32'h0057434D, 32'h00574350, 32'h00575042,
        32'h00575858, 32'h49504C53, 32'h544F5259, 32'h54594552
    };

    localparam logic [31:0] NEW_ID [ROM_SIZE] = '{
        32'h52425546, 32'h50434E54, 32'h434F4D4D, 32'h41454E43,
        32'h4554434F, 32'h47454F42, 32'h5449504C, 32'h4D434449,
        32'h4D4C4C54, 32'h41504943, 32'h504F504D, 32'h52565242,
        32'h53594C54, 32'h53595443, 32'h54414C42, 32'h5442504D,
        32'h54434F4D, 32'h54434F4E, 32'h54434D50, 32'h54434F50,
        32'h54444C59, 32'h54454E43, 32'h54464C54, 32'h544B4559,
        32'h544C414E, 32'h544D4544, 32'h544F414C, 32'h544F464E,
        32'h544F4C59, 32'h54444F52, 32'h544F414C, 32'h54504531,
        32'h54504532, 32'h54504533, 32'h54504534, 32'h54504F53,
        32'h54505542, 32'h54535243, 32'h54445243, 32'h5452434B,
        32'h54534F32, 32'h54534F41, 32'h54534F43, 32'h54534F50,
        32'h54535345, 32'h54534F54, 32'h54495431, 32'h54495432,
        32'h54495433, 32'h544F4C59, 32'h54585858, 32'h54445243,
        32'h55464944, 32'h55534C54, 32'h574F4146, 32'h574F4152,
        32'h574F4153, 32'h57434F4D, 32'h57434F50, 32'h57505542,
        32'h57585858, 32'h5449504C, 32'h54444F52, 32'h54445243
    };

    // First matching entry wins; unmatched IDs pass through.
    function automatic logic [31:0] map_id(input logic [31:0] id, input int entries);
        logic [31:0] res;
        logic        hit;
        res = id;
        hit = 1'b0;
        for (int i = 0; i < ROM_SIZE; i++) begin
            if (!hit && i < entries && OLD_ID[i] == id) begin
                res = NEW_ID[i];
                hit = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic logic char_ok(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

>>> sv/id3d_parser.sv
// Byte-at-a-time tag parser: state registers and the per-beat step logic.
module id3d_parser #(
    parameter int MAP_ENTRIES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat,
    input  logic [7:0]          in_byte,
    input  logic                in_start,
    output logic [1:0]          push_cnt,
    output id3d_pkg::result_t   res0,
    output id3d_pkg::result_t   res1
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR, PH_EXTLEN, PH_EXTSKIP, PH_FHDR, PH_FSKIP, PH_PAYLOAD, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fc_reg, fc_next;
    logic [27:0] tag_rem_reg, tag_rem_next;
    logic [27:0] tag_size_reg, tag_size_next;
    logic [2:0]  ver_reg, ver_next;
    logic [7:0]  tflags_reg, tflags_next;
    logic [31:0] code_reg, code_next;
    logic [31:0] frem_reg, frem_next;
    logic [15:0] fflags_reg, fflags_next;
    logic [31:0] skip_reg, skip_next;
    logic        tprev_reg, tprev_next;
    logic        fprev_reg, fprev_next;
    logic        held_vld_reg, held_vld_next;
    logic [7:0]  held_dat_reg, held_dat_next;
    logic        started_reg, started_next;
    logic        finp_reg, finp_next;

    id3d_pkg::result_t r0, r1;
    logic [1:0]        n;

    function automatic id3d_pkg::result_t mk(input logic [2:0] kind, input logic [31:0] code,
                                             input logic [7:0] pb, input logic first,
                                             input logic last, input logic [2:0] major,
                                             input logic [3:0] fault);
        id3d_pkg::result_t r;
        r.kind  = kind;
        r.code  = code;
        r.pbyte = pb;
        r.first = first;
        r.last  = last;
        r.major = major;
        r.fault = fault;
        return r;
    endfunction

    always_comb
    begin
        id3d_pkg::result_t nr;
        logic        have;
        logic        halted;
        logic [31:0] size;
        logic [15:0] f;
        logic [2:0]  need;
        logic [31:0] len;
        logic        idok;
        logic [3:0]  hs;
        logic [3:0]  ids;

        phase_next    = phase_reg;
        fc_next       = fc_reg;
        tag_rem_next  = tag_rem_reg;
        tag_size_next = tag_size_reg;
        ver_next      = ver_reg;
        tflags_next   = tflags_reg;
        code_next     = code_reg;
        frem_next     = frem_reg;
        fflags_next   = fflags_reg;
        skip_next     = skip_reg;
        tprev_next    = tprev_reg;
        fprev_next    = fprev_reg;
        held_vld_next = held_vld_reg;
        held_dat_next = held_dat_reg;
        started_next  = started_reg;
        finp_next     = finp_reg;
        r0 = '0;
        r1 = '0;
        n  = 2'd0;
        nr = '0;
        have = 1'b0;
        halted = 1'b0;
        size = '0;
        f = '0;
        need = '0;
        len = '0;
        idok = 1'b0;
        hs = 4'd10;
        ids = 4'd4;

        if (beat)
        begin
            // Pending finish from the previous beat goes out first.
            if (finp_reg)
            begin
                finp_next = 1'b0;
                r0 = mk(id3d_pkg::KIND_FINISH, '0, '0, 1'b0, 1'b0, ver_reg, id3d_pkg::FAULT_NONE);
                n  = 2'd1;
            end
            if (in_start)
            begin
                phase_next = PH_HDR;
                fc_next = '0; ver_next = '0; tflags_next = '0; tprev_next = 1'b0;
                fprev_next = 1'b0; tag_rem_next = '0; tag_size_next = '0; code_next = '0;
                frem_next = '0; skip_next = '0; fflags_next = '0; held_vld_next = 1'b0;
                held_dat_next = '0; started_next = 1'b0;
            end

            if (phase_next == PH_HDR)
            begin
                if ((fc_next == 4'd0 && in_byte != 8'h49) || (fc_next == 4'd1 && in_byte != 8'h44)
                    || (fc_next == 4'd2 && in_byte != 8'h33)
                    || (fc_next == 4'd3 && in_byte > 8'd4))
                begin
                    phase_next = PH_DONE;
                    nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0, ver_next,
                            id3d_pkg::FAULT_HEADER);
                    have = 1'b1;
                end
                else if (fc_next >= 4'd6 && in_byte[7])
                begin
                    phase_next = PH_DONE;
                    nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0, ver_next,
                            id3d_pkg::FAULT_SYNCHSAFE);
                    have = 1'b1;
                end
                else
                begin
                    if (fc_next == 4'd3)
                        ver_next = in_byte[2:0];
                    else if (fc_next == 4'd5)
                        tflags_next = in_byte;
                    else if (fc_next >= 4'd6)
                        tag_rem_next = {tag_rem_next[20:0], in_byte[6:0]};
                    fc_next = fc_next + 4'd1;
                    if (fc_next == 4'd10)
                    begin
                        tag_size_next = tag_rem_next;
                        tprev_next = 1'b0;
                        fc_next = '0;
                        skip_next = '0;
                        phase_next = tflags_next[6] ? PH_EXTLEN : PH_FHDR;
                        if (tag_rem_next == '0)
                        begin
                            if (phase_next == PH_FHDR)
                                nr = mk(id3d_pkg::KIND_FINISH, '0, '0, 1'b0, 1'b0, ver_next,
                                        id3d_pkg::FAULT_NONE);
                            else
                                nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0, ver_next,
                                        id3d_pkg::FAULT_OVERRUN);
                            phase_next = PH_DONE;
                            if (n == 2'd2 && nr.kind == id3d_pkg::KIND_FINISH)
                                finp_next = 1'b1;
                            else
                                have = 1'b1;
                        end
                    end
                end
                if (have && n < 2'd2)
                begin
                    if (n == 2'd0) r0 = nr; else r1 = nr;
                    n = n + 2'd1;
                end
            end
            else if (phase_next != PH_IDLE && phase_next != PH_DONE && tag_rem_next != '0)
            begin
                tag_rem_next = tag_rem_next - 28'd1;
                if (ver_next <= 3'd3 && tflags_next[7] && tprev_next && in_byte == 8'h00)
                    tprev_next = 1'b0;
                else
                begin
                    tprev_next = (in_byte == 8'hFF);
                    unique case (phase_next)
                        PH_EXTLEN:
                        begin
                            skip_next = {skip_next[23:0], in_byte};
                            fc_next = fc_next + 4'd1;
                            if (fc_next >= 4'd4)
                            begin
                                len = skip_next;
                                if (ver_next == 3'd4)
                                begin
                                    if (len < 32'd6)
                                    begin
                                        phase_next = PH_DONE;
                                        halted = 1'b1;
                                        nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0,
                                                ver_next, id3d_pkg::FAULT_EXT_SMALL);
                                        have = 1'b1;
                                    end
                                    len = len - 32'd4;
                                end
                                if (!halted)
                                begin
                                    if (len > {4'd0, tag_size_next})
                                    begin
                                        phase_next = PH_DONE;
                                        nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0,
                                                ver_next, id3d_pkg::FAULT_EXT_LARGE);
                                        have = 1'b1;
                                    end
                                    else
                                    begin
                                        skip_next = len;
                                        fc_next = '0;
                                        phase_next = (len != '0) ? PH_EXTSKIP : PH_FHDR;
                                    end
                                end
                            end
                        end
                        PH_EXTSKIP:
                        begin
                            skip_next = skip_next - 32'd1;
                            if (skip_next == '0)
                            begin
                                phase_next = PH_FHDR;
                                fc_next = '0;
                            end
                        end
                        PH_FSKIP:
                        begin
                            skip_next = skip_next - 32'd1;
                            if (skip_next == '0)
                            begin
                                if (frem_next == '0)
                                begin
                                    phase_next = PH_FHDR;
                                    fc_next = '0;
                                    nr = mk(id3d_pkg::KIND_EMPTY, code_next, '0, 1'b0, 1'b0,
                                            ver_next, id3d_pkg::FAULT_NONE);
                                    have = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_PAYLOAD;
                                    fprev_next = 1'b0;
                                    held_vld_next = 1'b0;
                                    held_dat_next = '0;
                                    started_next = 1'b0;
                                end
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            frem_next = frem_next - 32'd1;
                            if ((fflags_next[1] || (ver_next == 3'd4 && tflags_next[7]))
                                && fprev_next && in_byte == 8'h00)
                                fprev_next = 1'b0;
                            else
                            begin
                                fprev_next = (in_byte == 8'hFF);
                                if (held_vld_next && n < 2'd2)
                                begin
                                    nr = mk(id3d_pkg::KIND_PAYLOAD, code_next, held_dat_next,
                                            !started_next, 1'b0, ver_next,
                                            id3d_pkg::FAULT_NONE);
                                    if (n == 2'd0) r0 = nr; else r1 = nr;
                                    n = n + 2'd1;
                                end
                                if (held_vld_next)
                                    started_next = 1'b1;
                                held_vld_next = 1'b1;
                                held_dat_next = in_byte;
                            end
                            if (frem_next == '0)
                            begin
                                if (held_vld_next)
                                begin
                                    nr = mk(id3d_pkg::KIND_PAYLOAD, code_next, held_dat_next,
                                            !started_next, 1'b1, ver_next,
                                            id3d_pkg::FAULT_NONE);
                                    have = 1'b1;
                                    started_next = 1'b1;
                                    held_vld_next = 1'b0;
                                    held_dat_next = '0;
                                end
                                phase_next = PH_FHDR;
                                fc_next = '0;
                            end
                        end
                        PH_FHDR:
                        begin
                            hs  = (ver_next >= 3'd3) ? 4'd10 : 4'd6;
                            ids = (ver_next >= 3'd3) ? 4'd4 : 4'd3;
                            if (fc_next == 4'd0)
                            begin
                                code_next = '0;
                                frem_next = '0;
                                fflags_next = '0;
                            end
                            if (fc_next < ids)
                                code_next = {code_next[23:0], in_byte};
                            else if (fc_next < {ids[2:0], 1'b0})
                                frem_next = {frem_next[23:0], in_byte};
                            else
                                fflags_next = {fflags_next[7:0], in_byte};
                            fc_next = fc_next + 4'd1;
                            if (fc_next >= hs)
                            begin
                                fc_next = '0;
                                size = frem_next;
                                f = fflags_next;
                                if (ver_next == 3'd4)
                                begin
                                    if ((size & 32'h80808080) != '0)
                                    begin
                                        phase_next = PH_DONE;
                                        halted = 1'b1;
                                        nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0,
                                                ver_next, id3d_pkg::FAULT_SYNCHSAFE);
                                        have = 1'b1;
                                    end
                                    size = {4'd0, size[30:24], size[22:16], size[14:8], size[6:0]};
                                end
                                else if (ver_next == 3'd3)
                                    f = ((f & 16'he000) >> 1) | ((f & 16'h00c0) >> 4)
                                        | ((f & 16'h0020) << 1);
                                else
                                    f = '0;
                                if (!halted)
                                begin
                                    fflags_next = f;
                                    idok = id3d_pkg::char_ok(code_next[7:0])
                                        && id3d_pkg::char_ok(code_next[15:8])
                                        && id3d_pkg::char_ok(code_next[23:16])
                                        && (ver_next <= 3'd2
                                            || id3d_pkg::char_ok(code_next[31:24]));
                                    need = (f[0] ? 3'd4 : 3'd0) + (f[6] ? 3'd1 : 3'd0);
                                    if (code_next == '0)
                                    begin
                                        phase_next = PH_DONE;
                                        nr = mk(id3d_pkg::KIND_FINISH, '0, '0, 1'b0, 1'b0,
                                                ver_next, id3d_pkg::FAULT_NONE);
                                        if (n == 2'd2)
                                            finp_next = 1'b1;
                                        else
                                            have = 1'b1;
                                    end
                                    else if (!idok)
                                    begin
                                        phase_next = PH_DONE;
                                        nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0,
                                                ver_next, id3d_pkg::FAULT_FRAME_ID);
                                        have = 1'b1;
                                    end
                                    else
                                    begin
                                        if (ver_next < 3'd4)
                                            code_next = id3d_pkg::map_id(code_next, MAP_ENTRIES);
                                        if ((f & 16'h000c) != '0)
                                        begin
                                            phase_next = PH_DONE;
                                            nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0,
                                                    ver_next, id3d_pkg::FAULT_COMPRESS);
                                            have = 1'b1;
                                        end
                                        else if (size < {29'd0, need})
                                        begin
                                            phase_next = PH_DONE;
                                            nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0,
                                                    ver_next, id3d_pkg::FAULT_SMALL);
                                            have = 1'b1;
                                        end
                                        else
                                        begin
                                            frem_next = size - {29'd0, need};
                                            skip_next = {29'd0, need};
                                            if (need != '0)
                                                phase_next = PH_FSKIP;
                                            else if (frem_next == '0)
                                            begin
                                                phase_next = PH_FHDR;
                                                nr = mk(id3d_pkg::KIND_EMPTY, code_next, '0,
                                                        1'b0, 1'b0, ver_next,
                                                        id3d_pkg::FAULT_NONE);
                                                have = 1'b1;
                                            end
                                            else
                                            begin
                                                phase_next = PH_PAYLOAD;
                                                fprev_next = 1'b0;
                                                held_vld_next = 1'b0;
                                                held_dat_next = '0;
                                                started_next = 1'b0;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (have && n < 2'd2)
                    begin
                        if (n == 2'd0) r0 = nr; else r1 = nr;
                        n = n + 2'd1;
                    end
                end
                // End of tag: clean between frames, otherwise an overrun.
                if (phase_next != PH_DONE && tag_rem_next == '0)
                begin
                    if (phase_next == PH_FHDR)
                    begin
                        nr = mk(id3d_pkg::KIND_FINISH, '0, '0, 1'b0, 1'b0, ver_next,
                                id3d_pkg::FAULT_NONE);
                        if (n == 2'd2)
                            finp_next = 1'b1;
                    end
                    else
                        nr = mk(id3d_pkg::KIND_ERROR, '0, '0, 1'b0, 1'b0, ver_next,
                                id3d_pkg::FAULT_OVERRUN);
                    phase_next = PH_DONE;
                    if (n < 2'd2)
                    begin
                        if (n == 2'd0) r0 = nr; else r1 = nr;
                        n = n + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            fc_reg       <= '0;
            tag_rem_reg  <= '0;
            tag_size_reg <= '0;
            ver_reg      <= '0;
            tflags_reg   <= '0;
            code_reg     <= '0;
            frem_reg     <= '0;
            fflags_reg   <= '0;
            skip_reg     <= '0;
            tprev_reg    <= 1'b0;
            fprev_reg    <= 1'b0;
            held_vld_reg <= 1'b0;
            held_dat_reg <= '0;
            started_reg  <= 1'b0;
            finp_reg     <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fc_reg       <= fc_next;
            tag_rem_reg  <= tag_rem_next;
            tag_size_reg <= tag_size_next;
            ver_reg      <= ver_next;
            tflags_reg   <= tflags_next;
            code_reg     <= code_next;
            frem_reg     <= frem_next;
            fflags_reg   <= fflags_next;
            skip_reg     <= skip_next;
            tprev_reg    <= tprev_next;
            fprev_reg    <= fprev_next;
            held_vld_reg <= held_vld_next;
            held_dat_reg <= held_dat_next;
            started_reg  <= started_next;
            finp_reg     <= finp_next;
        end
    end

    assign push_cnt = n;
    assign res0 = r0;
    assign res1 = r1;

endmodule

>>> sv/id3d_result_fifo.sv
// Four-entry result queue: takes up to two results a cycle, hands out one while out_ready is high.
`include "assert_macros.svh"
module id3d_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  id3d_pkg::result_t res0,
    input  id3d_pkg::result_t res1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output id3d_pkg::result_t out_res
);

    id3d_pkg::result_t mem [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign wr_next   = wr_reg + push_cnt;
    assign rd_next   = rd_reg + {1'b0, pop};
    assign cnt_next  = cnt_reg + {1'b0, push_cnt} - {2'b00, pop};
    assign room      = (cnt_reg <= 3'd2);
    assign out_valid = (cnt_reg != 3'd0);
    assign out_res   = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem[wr_reg] <= res0;
        if (push_cnt == 2'd2)
            mem[wr_reg + 2'd1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_reg <= 3'd4)
    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push_cnt != 2'd0, ({1'b0, cnt_reg} + {2'b00, push_cnt}) <= 4'd4)
    `ASSERT_IMPLY(a_one_push_max_when_nearly_full, clk, rst_n, cnt_reg == 3'd3, push_cnt != 2'd2)
    `ASSERT_NEXT(a_ptr_gap, clk, rst_n, 1'b1, (wr_reg - rd_reg) == cnt_reg[1:0])

endmodule

>>> sv/id3v2_frame_deframer_core.sv
// Top level of the ID3v2 tag deframer: stream ports, parser and result queue.
//
// Feed the raw bytes of an ID3v2 tag one beat at a time, setting tuser on the
// first byte of the 10-byte tag header; that beat restarts parsing from scratch.
// The core checks the "ID3" mark, a major version of 4 or less and the
// synchsafe size, removes unsynchronization (whole tag for versions up to 3,
// per frame payload for version 4), skips the extended header, parses 6- or
// 10-byte frame headers, maps old three-letter and version 3 IDs to version 4
// IDs, drops data-length and group bytes and then hands out payload bytes
// tagged with their frame ID. Each output beat carries one result: a payload
// byte, an empty frame, tag finished or an error code; after a finish or an
// error, bytes are ignored until the next start beat. Bytes before any start
// are ignored. Timing: each input byte is processed in the cycle it is
// accepted, so the core takes one byte per clock, but stalls while the queue
// has fewer than two free slots. A byte yields zero, one or two results;
// these go through a four-entry queue that drains one result per clock while
// tready is high. Each payload byte is held until the next, and the held byte
// goes out with tlast as the frame ends, so that tlast is exact; a tag finish
// that collides with two other results is sent with the following byte.
module id3v2_frame_deframer_core #(
    parameter int MAP_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // tag_byte
    input  logic [0:0]  s_axis_tuser,   // tag_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // frame_code, payload_byte, frame_first, tag_major,
                                        // fault_code
    output logic [2:0]  m_axis_tuser,   // item_kind
    output logic        m_axis_tlast    // frame_last
);

    logic              beat;
    logic [1:0]        push_cnt;
    logic              room;
    id3d_pkg::result_t res0, res1, head;

    // Accept a byte only when the queue can absorb two results.
    assign s_axis_tready = room;
    assign beat = s_axis_tvalid && room;

    id3d_parser #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .beat     (beat),
        .in_byte  (s_axis_tdata),
        .in_start (s_axis_tuser[0]),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    id3d_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (head)
    );

    // Pack the result fields from the lowest bit up.
    assign m_axis_tdata = {head.fault, head.major, head.first, head.pbyte, head.code};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule
